### hw/rtl/tpr_pkg.sv
// shared types, register indexes and speed codes for the touch press relay controller
package tpr_pkg;

  localparam int CfgIndexWidth = 2;
  localparam int CfgDataWidth  = 24;

  localparam logic [CfgIndexWidth-1:0] REG_DEBOUNCE      = 2'd0;
  localparam logic [CfgIndexWidth-1:0] REG_LONG_PRESS    = 2'd1;
  localparam logic [CfgIndexWidth-1:0] REG_IDLE_TIMEOUT  = 2'd2;
  localparam logic [CfgIndexWidth-1:0] REG_SAMPLE_PERIOD = 2'd3;

  localparam logic [11:0] DEBOUNCE_RESET      = 12'd50;
  localparam logic [15:0] LONG_PRESS_RESET    = 16'd1000;
  localparam logic [23:0] IDLE_TIMEOUT_RESET  = 24'd600000;
  localparam logic [15:0] SAMPLE_PERIOD_RESET = 16'd500;

  localparam logic [15:0] MAX16 = 16'hFFFF;
  localparam logic [23:0] MAX24 = 24'hFFFFFF;

  localparam logic [6:0] FLOW_SPEED_FAST = 7'd100;
  localparam logic [6:0] FLOW_SPEED_MID  = 7'd20;
  localparam logic [6:0] FLOW_SPEED_SLOW = 7'd10;

  typedef enum logic [1:0] {
    SPEED_100 = 2'd0,
    SPEED_20  = 2'd1,
    SPEED_10  = 2'd2
  } speed_t;

  typedef struct packed {
    logic [11:0] debounce_ms;
    logic [15:0] long_press_ms;
    logic [23:0] idle_timeout_ms;
    logic [15:0] sample_period_ms;
  } tpr_cfg_t;

  typedef struct packed {
    logic       relay_on;
    logic [6:0] flow_speed;
    logic       touch_stable;
    logic       press_was_long;
    logic       motion_seen;
  } tpr_result_t;

  function automatic logic [6:0] speed_value(input speed_t code);
    logic [6:0] v;
    case (code)
      SPEED_20: v = FLOW_SPEED_MID;
      SPEED_10: v = FLOW_SPEED_SLOW;
      default:  v = FLOW_SPEED_FAST;
    endcase
    return v;
  endfunction

  // code three is unreachable; it steps back to the fast speed
  function automatic speed_t speed_step(input speed_t code);
    speed_t v;
    case (code)
      SPEED_100: v = SPEED_20;
      SPEED_20:  v = SPEED_10;
      default:   v = SPEED_100;
    endcase
    return v;
  endfunction

endpackage

### hw/rtl/tpr_cfg.sv
// configuration register file with its write decoder
module tpr_cfg (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [tpr_pkg::CfgIndexWidth-1:0]    cfg_index,
  input  logic [tpr_pkg::CfgDataWidth-1:0]     cfg_data,
  output tpr_pkg::tpr_cfg_t                    cfg
);

  tpr_pkg::tpr_cfg_t regs;

  assign cfg_ready = 1'b1;
  assign cfg      = regs;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.debounce_ms      <= tpr_pkg::DEBOUNCE_RESET;
      regs.long_press_ms    <= tpr_pkg::LONG_PRESS_RESET;
      regs.idle_timeout_ms  <= tpr_pkg::IDLE_TIMEOUT_RESET;
      regs.sample_period_ms <= tpr_pkg::SAMPLE_PERIOD_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        tpr_pkg::REG_DEBOUNCE:      regs.debounce_ms      <= cfg_data[11:0];
        tpr_pkg::REG_LONG_PRESS:    regs.long_press_ms    <= cfg_data[15:0];
        tpr_pkg::REG_IDLE_TIMEOUT:  regs.idle_timeout_ms  <= cfg_data[23:0];
        tpr_pkg::REG_SAMPLE_PERIOD: regs.sample_period_ms <= cfg_data[15:0];
      endcase
    end
  end

endmodule

### hw/rtl/tpr_core.sv
// tick state: debounce, press length, motion sampling and relay/speed update
module tpr_core (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  step,
  input  logic                  touch,
  input  logic                  motion,
  input  tpr_pkg::tpr_cfg_t     cfg,
  output tpr_pkg::tpr_result_t  result
);

  logic           prev_touch, prev_touch_next;
  logic           stable_touch, stable_touch_next;
  logic [15:0]    since_change, since_change_next;
  logic [15:0]    press_length, press_length_next;
  logic           long_flag, long_flag_next;
  logic           relay_state, relay_state_next;
  tpr_pkg::speed_t speed_code, speed_code_next;
  logic [15:0]    sample_count, sample_count_next;
  logic [23:0]    idle_count, idle_count_next;
  logic           motion_latched, motion_latched_next;

  always_comb begin
    since_change_next = (since_change == tpr_pkg::MAX16) ? since_change : since_change + 16'd1;
    press_length_next = (press_length == tpr_pkg::MAX16) ? press_length : press_length + 16'd1;
    sample_count_next = (sample_count == tpr_pkg::MAX16) ? sample_count : sample_count + 16'd1;
    idle_count_next   = (idle_count == tpr_pkg::MAX24) ? idle_count : idle_count + 24'd1;
    motion_latched_next = motion_latched;
    relay_state_next    = relay_state;
    long_flag_next      = long_flag;
    stable_touch_next   = stable_touch;
    speed_code_next     = speed_code;
    prev_touch_next     = touch;

    // motion sample and idle timeout
    if (sample_count_next >= cfg.sample_period_ms) begin
      sample_count_next   = 16'd0;
      motion_latched_next = motion;
      if (motion) idle_count_next = 24'd0;
      if (relay_state && (idle_count_next > cfg.idle_timeout_ms)) relay_state_next = 1'b0;
    end

    // raw touch edge
    if (touch != prev_touch) begin
      since_change_next = 16'd0;
      if (touch) begin
        press_length_next = 16'd0;
        long_flag_next    = 1'b0;
      end else begin
        long_flag_next = (press_length_next >= cfg.long_press_ms);
      end
    end

    // debounced release action
    if (since_change_next > {4'd0, cfg.debounce_ms}) begin
      if (!touch && stable_touch) begin
        if (long_flag_next) speed_code_next = tpr_pkg::speed_step(speed_code);
        else                relay_state_next = ~relay_state_next;
      end
      stable_touch_next = touch;
    end
  end

  always_comb begin
    result.relay_on       = relay_state_next;
    result.flow_speed     = tpr_pkg::speed_value(speed_code_next);
    result.touch_stable   = stable_touch_next;
    result.press_was_long = long_flag_next;
    result.motion_seen    = motion_latched_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_touch     <= 1'b0;
      stable_touch   <= 1'b0;
      since_change   <= 16'd0;
      press_length   <= 16'd0;
      long_flag      <= 1'b0;
      relay_state    <= 1'b0;
      speed_code     <= tpr_pkg::SPEED_100;
      sample_count   <= 16'd0;
      idle_count     <= 24'd0;
      motion_latched <= 1'b0;
    end else if (step) begin
      prev_touch     <= prev_touch_next;
      stable_touch   <= stable_touch_next;
      since_change   <= since_change_next;
      press_length   <= press_length_next;
      long_flag      <= long_flag_next;
      relay_state    <= relay_state_next;
      speed_code     <= speed_code_next;
      sample_count   <= sample_count_next;
      idle_count     <= idle_count_next;
      motion_latched <= motion_latched_next;
    end
  end

endmodule

### hw/rtl/touch_press_relay_controller_top.sv
// touch press relay controller top: input register, tick core, result register
// path: a tick accepted into the input register is processed by the tick core and
//   captured in the result register, with out_valid, when the result register can advance
// throughput: one tick per clock; the input and result registers advance together
//   whenever the result register is empty or being taken
// reset: synchronous rst clears both valid bits, all counters and flags, and loads
//   the register defaults (debounce 50, long press 1000, timeout 600000, sample 500)
module touch_press_relay_controller_top (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                touch_level,
  input  logic                                motion_level,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                relay_on,
  output logic [6:0]                          flow_speed,
  output logic                                touch_stable,
  output logic                                press_was_long,
  output logic                                motion_seen,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [tpr_pkg::CfgIndexWidth-1:0]   cfg_index,
  input  logic [tpr_pkg::CfgDataWidth-1:0]    cfg_data
);

  tpr_pkg::tpr_cfg_t    cfg;
  tpr_pkg::tpr_result_t core_result;
  tpr_pkg::tpr_result_t out_reg;

  logic in_vld;
  logic in_touch, in_motion;
  logic advance;
  logic step;

  assign advance  = !out_valid || out_ready;
  assign step     = in_vld && advance;
  assign in_ready = !in_vld || advance;

  tpr_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  tpr_core u_core (
    .clk    (clk),
    .rst    (rst),
    .step   (step),
    .touch  (in_touch),
    .motion (in_motion),
    .cfg    (cfg),
    .result (core_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (in_ready) begin
      in_vld <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_touch  <= touch_level;
      in_motion <= motion_level;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_reg <= core_result;
    end
  end

  assign relay_on       = out_reg.relay_on;
  assign flow_speed     = out_reg.flow_speed;
  assign touch_stable   = out_reg.touch_stable;
  assign press_was_long = out_reg.press_was_long;
  assign motion_seen    = out_reg.motion_seen;

endmodule

### hw/rtl/tpr_checker.sv
// port-level checker for the touch press relay controller, bound to the top level
module tpr_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic       relay_on,
  input logic [6:0] flow_speed,
  input logic       touch_stable,
  input logic       press_was_long,
  input logic       motion_seen
);

  // a stalled result transaction keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(relay_on) && $stable(flow_speed)
      && $stable(touch_stable) && $stable(press_was_long) && $stable(motion_seen))
    else $error("result payload changed while stalled");

  a_speed_legal: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (flow_speed == 7'd100 || flow_speed == 7'd20 || flow_speed == 7'd10))
    else $error("flow speed outside 100, 20, 10");

  // with the result register empty the pipe must take a new tick
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty result register");

  a_reset_clears: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind touch_press_relay_controller_top tpr_checker u_tpr_checker (
  .clk            (clk),
  .rst            (rst),
  .in_ready       (in_ready),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .relay_on       (relay_on),
  .flow_speed     (flow_speed),
  .touch_stable   (touch_stable),
  .press_was_long (press_was_long),
  .motion_seen    (motion_seen)
);
